// ===== hw/rtl/vspe_pkg.sv =====
// Shared types, codes and reset values for the valve step position executor.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vspe_pkg;

	localparam int FIFO_DEPTH_DEF  = 16;
	localparam int VALVE_COUNT_DEF = 2;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// command codes
	localparam logic [1:0] CMD_INIT  = 2'd0;
	localparam logic [1:0] CMD_CLOSE = 2'd1;
	localparam logic [1:0] CMD_RUN   = 2'd2;

	// motion codes
	localparam logic [1:0] MOTION_NONE = 2'd0;
	localparam logic [1:0] MOTION_UP   = 2'd1;
	localparam logic [1:0] MOTION_DOWN = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_INIT_STEP     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_STEP    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_STEP      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEP_MAIN = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEP_SUB  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS  = 3'd5;

	// register reset values
	localparam logic signed [15:0] RST_INIT_STEP     = 16'sd0;
	localparam logic [9:0]         RST_CLOSE_STEP    = 10'd8;
	localparam logic [11:0]        RST_MIN_STEP      = 12'd30;
	localparam logic [11:0]        RST_MAX_STEP_MAIN = 12'd470;
	localparam logic [11:0]        RST_MAX_STEP_SUB  = 12'd270;
	localparam logic [7:0]         RST_SETTLE_TICKS  = 8'd10;

	typedef struct packed {
		logic signed [15:0] init_step;
		logic [9:0]         close_step;
		logic [11:0]        min_step;
		logic [11:0]        max_step_main;
		logic [11:0]        max_step_sub;
		logic [7:0]         settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic               valve;
		logic [1:0]         command;
		logic signed [15:0] delta;
	} cmd_entry_t;

	typedef struct packed {
		logic signed [15:0] remaining;
		logic signed [15:0] position;
		logic               busy;
		logic [7:0]         settle;
	} valve_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vspe_cmd_fifo.sv =====
// Command FIFO: synchronous memory, head/tail/count registers and a read bypass.
// Depends on vspe_pkg.
`default_nettype none

module vspe_cmd_fifo #(
	parameter int FIFO_DEPTH = vspe_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire logic                 push,
	input  wire logic                 pop,
	input  wire vspe_pkg::cmd_entry_t wr_entry,
	output vspe_pkg::cmd_entry_t      head_entry,
	output logic                      not_empty,
	output logic                      full
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

	vspe_pkg::cmd_entry_t mem [FIFO_DEPTH];

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] rd_addr;
	vspe_pkg::cmd_entry_t rd_q;

	assign head_inc  = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
	assign tail_inc  = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
	// read where the head will stand after this cycle's pop
	assign rd_addr   = pop ? head_inc : head_q;
	assign not_empty = (count_q != '0);
	assign full      = (count_q == FULL_CNT);
	assign head_entry = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q  <= tail_inc;
				count_q <= count_q + 1'b1;
			end else if (pop) begin
				head_q  <= head_inc;
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= wr_entry;
		end
	end

	// forward an entry written in the same cycle as the read
	always_ff @(posedge clk) begin
		if (load) begin
			if (push && (tail_q == rd_addr)) begin
				rd_q <= wr_entry;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/vspe_valve_mem.sv =====
// Per-valve state memory with registered read, valid bits and write forwarding.
// Depends on vspe_pkg.
`default_nettype none

module vspe_valve_mem #(
	parameter int VALVE_COUNT = vspe_pkg::VALVE_COUNT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   rd_en,
	input  wire logic                   rd_addr,
	output vspe_pkg::valve_state_t      rd_state,
	input  wire logic                   wr_en,
	input  wire logic                   wr_addr,
	input  wire vspe_pkg::valve_state_t wr_state
);

	localparam logic [1:0] VC = 2'(VALVE_COUNT);

	vspe_pkg::valve_state_t mem [VALVE_COUNT];
	logic [VALVE_COUNT-1:0] valid_q;
	vspe_pkg::valve_state_t rd_q;
	logic rd_in_range;
	logic wr_in_range;

	assign rd_in_range = ({1'b0, rd_addr} < VC);
	assign wr_in_range = ({1'b0, wr_addr} < VC);
	assign rd_state    = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en && wr_in_range) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem[wr_addr] <= wr_state;
		end
	end

	// an entry never written reads as the reset state
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_in_range && (wr_addr == rd_addr)) begin
				rd_q <= wr_state;
			end else if (rd_in_range && valid_q[rd_addr]) begin
				rd_q <= mem[rd_addr];
			end else begin
				rd_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/vspe_step_unit.sv =====
// Next-state logic for one request: push decision, command apply, stepping, settling.
// Depends on vspe_pkg.
`default_nettype none

module vspe_step_unit (
	input  wire logic                   operation,
	input  wire logic                   valve,
	input  wire logic                   used,
	input  wire vspe_pkg::valve_state_t cur,
	input  wire vspe_pkg::cmd_entry_t   head,
	input  wire logic                   not_empty,
	input  wire logic                   full,
	input  wire vspe_pkg::cfg_t         cfg,
	output vspe_pkg::valve_state_t      nxt,
	output logic [1:0]                  motion,
	output logic                        accepted,
	output logic                        pop_req,
	output logic                        push_req
);

	logic signed [16:0] pos_x;
	logic signed [16:0] lo;
	logic signed [16:0] hi;
	logic signed [16:0] sum;
	logic signed [16:0] close_neg;
	logic signed [16:0] to_lo;
	logic signed [16:0] to_hi;

	assign pos_x     = {cur.position[15], cur.position};
	assign lo        = $signed({5'b0, cfg.min_step});
	assign hi        = valve ? $signed({5'b0, cfg.max_step_sub})
	                         : $signed({5'b0, cfg.max_step_main});
	assign sum       = pos_x + {head.delta[15], head.delta};
	assign close_neg = -(pos_x + $signed({7'b0, cfg.close_step}));
	assign to_lo     = lo - pos_x;
	assign to_hi     = hi - pos_x;

	always_comb begin
		nxt      = cur;
		motion   = vspe_pkg::MOTION_NONE;
		accepted = 1'b0;
		pop_req  = 1'b0;
		push_req = 1'b0;
		if (operation == vspe_pkg::OP_PUSH) begin
			push_req = !full;
			accepted = !full;
		end else if (used) begin
			if (!cur.busy && not_empty && (head.valve == valve)) begin
				pop_req  = 1'b1;
				nxt.busy = 1'b1;
				case (head.command)
					vspe_pkg::CMD_INIT: begin
						nxt.remaining = cfg.init_step;
						nxt.position  = '0;
					end
					vspe_pkg::CMD_CLOSE: begin
						nxt.remaining = close_neg[15:0];
						nxt.position  = '0;
					end
					vspe_pkg::CMD_RUN: begin
						// min limit is checked first; when min is above max, a sum below min clamps to min, any other to max
						if (sum < lo) begin
							nxt.remaining = to_lo[15:0];
							nxt.position  = lo[15:0];
						end else if (sum > hi) begin
							nxt.remaining = to_hi[15:0];
							nxt.position  = hi[15:0];
						end else begin
							nxt.remaining = head.delta;
							nxt.position  = sum[15:0];
						end
					end
					default: begin
						// unknown command: pop it and only mark busy so the valve settles
					end
				endcase
			end else if (cur.remaining == '0) begin
				if (cur.busy) begin
					if (cur.settle >= cfg.settle_ticks) begin
						nxt.busy   = 1'b0;
						nxt.settle = '0;
					end else begin
						nxt.settle = cur.settle + 1'b1;
					end
				end
			end else if (cur.remaining[15]) begin
				nxt.remaining = cur.remaining + 16'sd1;
				motion        = vspe_pkg::MOTION_UP;
			end else begin
				nxt.remaining = cur.remaining - 16'sd1;
				motion        = vspe_pkg::MOTION_DOWN;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/valve_step_position_executor_unit.sv =====
// Top level of the valve step position executor: config registers, pipeline, output register.
// Depends on vspe_pkg, vspe_cmd_fifo, vspe_valve_mem and vspe_step_unit.
`default_nettype none

// Drives up to two stepper expansion valves from one shared command FIFO. Each request is
// either a push (init, close or run command for a valve) or a tick for one valve, and gives
// exactly one result. Throughput is one request per cycle while out_ready keeps the output
// register draining; a request is taken into stage 1 while the valve state and FIFO head
// are read, and its result is written into the output register when stage 1 fires. The
// per-valve state lives in a small memory read as a request enters stage 1 and written back
// as it leaves, with forwarding when consecutive requests touch the same valve or the FIFO
// entry just pushed. The state memory comes out of reset cleared through per-entry valid
// bits, so no clearing pass is needed. Configuration writes take effect at once and belong
// in idle periods.
module valve_step_position_executor_unit #(
	parameter int FIFO_DEPTH  = vspe_pkg::FIFO_DEPTH_DEF,
	parameter int VALVE_COUNT = vspe_pkg::VALVE_COUNT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [vspe_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [vspe_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               operation,
	input  wire logic                               valve,
	input  wire logic [1:0]                         command,
	input  wire logic signed [15:0]                 delta,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    valve_out,
	output logic [1:0]                              motion,
	output logic                                    running,
	output logic signed [15:0]                      position,
	output logic                                    push_accepted
);

	localparam logic [1:0] VC = 2'(VALVE_COUNT);

	vspe_pkg::cfg_t cfg_q;

	logic               valid_s1;
	logic               operation_s1;
	logic               valve_s1;
	logic [1:0]         command_s1;
	logic signed [15:0] delta_s1;
	logic               used_s1;
	logic               fire_s1;
	logic               accept;

	logic               out_valid_q;
	logic               valve_out_q;
	logic [1:0]         motion_q;
	logic               running_q;
	logic signed [15:0] position_q;
	logic               push_accepted_q;

	vspe_pkg::cmd_entry_t   head_entry;
	vspe_pkg::cmd_entry_t   push_entry;
	vspe_pkg::valve_state_t cur_state;
	vspe_pkg::valve_state_t nxt_state;
	logic                   fifo_not_empty;
	logic                   fifo_full;
	logic                   pop_req;
	logic                   push_req;
	logic [1:0]             step_motion;
	logic                   step_accepted;
	logic                   state_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_step     <= vspe_pkg::RST_INIT_STEP;
			cfg_q.close_step    <= vspe_pkg::RST_CLOSE_STEP;
			cfg_q.min_step      <= vspe_pkg::RST_MIN_STEP;
			cfg_q.max_step_main <= vspe_pkg::RST_MAX_STEP_MAIN;
			cfg_q.max_step_sub  <= vspe_pkg::RST_MAX_STEP_SUB;
			cfg_q.settle_ticks  <= vspe_pkg::RST_SETTLE_TICKS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				vspe_pkg::REG_INIT_STEP:     cfg_q.init_step     <= $signed(cfg_data);
				vspe_pkg::REG_CLOSE_STEP:    cfg_q.close_step    <= cfg_data[9:0];
				vspe_pkg::REG_MIN_STEP:      cfg_q.min_step      <= cfg_data[11:0];
				vspe_pkg::REG_MAX_STEP_MAIN: cfg_q.max_step_main <= cfg_data[11:0];
				vspe_pkg::REG_MAX_STEP_SUB:  cfg_q.max_step_sub  <= cfg_data[11:0];
				vspe_pkg::REG_SETTLE_TICKS:  cfg_q.settle_ticks  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1 advances when the output register is free or being emptied
	assign fire_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;
	assign accept   = in_valid && in_ready;
	assign used_s1  = ({1'b0, valve_s1} < VC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			operation_s1 <= operation;
			valve_s1     <= valve;
			command_s1   <= command;
			delta_s1     <= delta;
		end
	end

	assign push_entry.valve   = valve_s1;
	assign push_entry.command = command_s1;
	assign push_entry.delta   = delta_s1;

	vspe_cmd_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.push       (fire_s1 && push_req),
		.pop        (fire_s1 && pop_req),
		.wr_entry   (push_entry),
		.head_entry (head_entry),
		.not_empty  (fifo_not_empty),
		.full       (fifo_full)
	);

	assign state_wr = fire_s1 && (operation_s1 == vspe_pkg::OP_TICK) && used_s1;

	vspe_valve_mem #(
		.VALVE_COUNT(VALVE_COUNT)
	) u_state_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (valve),
		.rd_state (cur_state),
		.wr_en    (state_wr),
		.wr_addr  (valve_s1),
		.wr_state (nxt_state)
	);

	vspe_step_unit u_step (
		.operation (operation_s1),
		.valve     (valve_s1),
		.used      (used_s1),
		.cur       (cur_state),
		.head      (head_entry),
		.not_empty (fifo_not_empty),
		.full      (fifo_full),
		.cfg       (cfg_q),
		.nxt       (nxt_state),
		.motion    (step_motion),
		.accepted  (step_accepted),
		.pop_req   (pop_req),
		.push_req  (push_req)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			valve_out_q     <= valve_s1;
			motion_q        <= step_motion;
			running_q       <= used_s1 && nxt_state.busy;
			position_q      <= used_s1 ? nxt_state.position : 16'sd0;
			push_accepted_q <= step_accepted;
		end
	end

	assign out_valid     = out_valid_q;
	assign valve_out     = valve_out_q;
	assign motion        = motion_q;
	assign running       = running_q;
	assign position      = position_q;
	assign push_accepted = push_accepted_q;

endmodule

`default_nettype wire
